// ===== rtl/qbs_pkg.sv =====
// ----------------------------------------------------------------------------
// qbs_pkg: shared definitions for the quadratic Bezier sampler
// Register indexes, widths, default parameter values and sequencer states.
// ----------------------------------------------------------------------------
package qbs_pkg;

    localparam int DEF_MAX_SEGMENTS_LOG2 = 10;
    localparam int DEF_COORD_WIDTH       = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int SEG_LOG2_W  = 4;

    localparam logic [SEG_LOG2_W-1:0] SEG_LOG2_RESET = 4'd7;

    localparam logic [CFG_INDEX_W-1:0] REG_START_X       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_X        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_Y        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_END_X         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_END_Y         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENTS_LOG2 = 3'd6;

    typedef enum logic [1:0] {
        QBS_IDLE,
        QBS_RUN,
        QBS_DONE
    } qbs_state_t;

endpackage

// ===== rtl/qbs_mul.sv =====
// ----------------------------------------------------------------------------
// qbs_mul: registered shared multiplier
// Unsigned weight times signed operand, product registered.
// ----------------------------------------------------------------------------
module qbs_mul
    import qbs_pkg::*;
#(
    parameter int AW = 21,
    parameter int BW = 16
)
(
    input  logic                     clk,
    input  logic [AW-1:0]            a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW:0]    p
);

    logic signed [AW+BW:0] p_reg;
    logic signed [AW+BW:0] p_next;

    assign p_next = $signed({1'b0, a}) * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== rtl/quadratic_bezier_sampler.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_sampler: quadratic Bezier curve flattener
// Samples a configured three-point curve at t = k/N with a running box.
// ----------------------------------------------------------------------------
// Usage. The six control point coordinates and the segment exponent are
// written through the configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and writes are meant to happen while the
// block is idle. Each beat on the input channel (in_valid, in_ready, restart)
// asks for one sample: restart high goes back to t = 0 and clears the bounding
// box, restart low moves on to the next sample. Past the curve end the end
// point is repeated with last set.
// Each beat gives one beat on the output channel carrying the point, the last
// flag and the bounding box including that point. The output is held in a
// register, so a stalled receiver does not hold up the work on the next beat;
// only the final load waits for the register to empty.
// The block takes a new input beat only while idle, once the previous sample
// has been loaded into the output register, and a stall on the output holds
// that load. The work is done by the single registered multiplier, which forms
// the squares of k and N-k and then six weight-times-coordinate products in
// turn, followed by the divide by N squared and then the box update.
// Reset clears the control points, sets the segment exponent to 7, returns the
// sample index to zero and sets the box to its empty state (minimum at the
// largest positive coordinate, maximum at zero).
// ----------------------------------------------------------------------------
module quadratic_bezier_sampler
    import qbs_pkg::*;
#(
    parameter int MAX_SEGMENTS_LOG2 = DEF_MAX_SEGMENTS_LOG2,
    parameter int COORD_WIDTH       = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic                          last,
    output logic signed [COORD_WIDTH-1:0] box_min_x,
    output logic signed [COORD_WIDTH-1:0] box_min_y,
    output logic signed [COORD_WIDTH-1:0] box_max_x,
    output logic signed [COORD_WIDTH-1:0] box_max_y,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int KW  = MAX_SEGMENTS_LOG2 + 1;          // sample index, holds N
    localparam int AW  = 2 * MAX_SEGMENTS_LOG2 + 1;      // weights, up to N squared
    localparam int BW  = (MAX_SEGMENTS_LOG2 + 2 > CW) ? MAX_SEGMENTS_LOG2 + 2 : CW;
    localparam int PW  = AW + BW + 1;                    // product and sum width
    localparam int LGW = $clog2(MAX_SEGMENTS_LOG2 + 1);
    localparam int SW  = LGW + 1;                        // shift by twice the exponent

    localparam logic signed [CW-1:0] BOX_MIN_RESET = {1'b0, {(CW-1){1'b1}}};

    // Sequencer steps while running.
    localparam logic [3:0] STEP_SQ_K  = 4'd0;
    localparam logic [3:0] STEP_SQ_R  = 4'd1;
    localparam logic [3:0] STEP_W0    = 4'd2;
    localparam logic [3:0] STEP_X0    = 4'd3;
    localparam logic [3:0] STEP_X1    = 4'd4;
    localparam logic [3:0] STEP_X2    = 4'd5;
    localparam logic [3:0] STEP_Y0    = 4'd6;
    localparam logic [3:0] STEP_Y1    = 4'd7;
    localparam logic [3:0] STEP_Y2    = 4'd8;
    localparam logic [3:0] STEP_SUM_Y = 4'd9;
    localparam logic [3:0] STEP_DIV   = 4'd10;

    // Configuration registers.
    logic signed [CW-1:0]     start_x_reg, start_y_reg;
    logic signed [CW-1:0]     ctrl_x_reg, ctrl_y_reg;
    logic signed [CW-1:0]     end_x_reg, end_y_reg;
    logic [SEG_LOG2_W-1:0]    seg_log2_reg;

    // Control state.
    qbs_state_t               state_reg, state_next;
    logic [3:0]               step_reg, step_next;
    logic [KW-1:0]            sample_index_reg, sample_index_next;
    logic                     out_valid_reg, out_valid_next;

    // Running box.
    logic signed [CW-1:0]     min_x_reg, min_y_reg, max_x_reg, max_y_reg;

    // Per-sample working registers.
    logic [KW-1:0]            k_reg, r_reg;
    logic                     last_reg;
    logic [LGW-1:0]           lg_reg;
    logic [AW-1:0]            w0_reg, w1_reg, w2_reg;
    logic signed [PW-1:0]     acc_reg, num_x_reg, num_y_reg;
    logic signed [CW-1:0]     px_reg, py_reg;

    // Output registers.
    logic signed [CW-1:0]     point_x_reg, point_y_reg;
    logic                     last_out_reg;
    logic signed [CW-1:0]     box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;

    // Handshake decisions.
    logic                     accept;
    logic                     finish;

    // Sample set-up from the current index.
    logic [LGW-1:0]           lg_eff;
    logic [KW-1:0]            n_val, k_cur, k_eff;
    logic                     last_eff;

    // Shared multiplier.
    logic [AW-1:0]            mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [PW-1:0]     prod;

    // Divide by N squared, truncating toward zero.
    logic [SW-1:0]            sh;
    logic signed [PW-1:0]     nsq_pw, bias_x, bias_y, quot_x, quot_y;
    logic [AW-1:0]            nsq_aw;
    logic signed [PW-1:0]     sum_next;

    // Box candidates.
    logic signed [CW-1:0]     min_x_new, min_y_new, max_x_new, max_y_new;

    // ------------------------------------------------------------------
    // Segment exponent saturates at the build limit; the index is clamped
    // to N when the segment count has been lowered part way along.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (int'(seg_log2_reg) > MAX_SEGMENTS_LOG2)
            lg_eff = LGW'(MAX_SEGMENTS_LOG2);
        else
            lg_eff = LGW'(seg_log2_reg);
        n_val    = KW'(1) << lg_eff;
        k_cur    = restart ? '0 : sample_index_reg;
        k_eff    = (k_cur > n_val) ? n_val : k_cur;
        last_eff = (k_eff == n_val);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and handshake.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        sample_index_next = sample_index_reg;
        out_valid_next    = out_valid_reg;
        accept            = 1'b0;
        finish            = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            QBS_IDLE:
            begin
                if (in_valid)
                begin
                    accept            = 1'b1;
                    state_next        = QBS_RUN;
                    step_next         = STEP_SQ_K;
                    sample_index_next = last_eff ? n_val : k_eff + KW'(1);
                end
            end
            QBS_RUN:
            begin
                if (step_reg == STEP_DIV)
                    state_next = QBS_DONE;
                else
                    step_next = step_reg + 4'd1;
            end
            QBS_DONE:
            begin
                // Load the output register only when it is empty or being read in this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    finish         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = QBS_IDLE;
                end
            end
            default:
            begin
                state_next = QBS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= QBS_IDLE;
            step_reg         <= STEP_SQ_K;
            sample_index_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            sample_index_reg <= sample_index_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            ctrl_x_reg   <= '0;
            ctrl_y_reg   <= '0;
            end_x_reg    <= '0;
            end_y_reg    <= '0;
            seg_log2_reg <= SEG_LOG2_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_X:       start_x_reg  <= $signed(cfg_data);
                REG_START_Y:       start_y_reg  <= $signed(cfg_data);
                REG_CTRL_X:        ctrl_x_reg   <= $signed(cfg_data);
                REG_CTRL_Y:        ctrl_y_reg   <= $signed(cfg_data);
                REG_END_X:         end_x_reg    <= $signed(cfg_data);
                REG_END_Y:         end_y_reg    <= $signed(cfg_data);
                REG_SEGMENTS_LOG2: seg_log2_reg <= cfg_data[SEG_LOG2_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared multiplier. The weights are
    // (N-k)^2, 2k(N-k) and k^2; the middle one is N^2 less the other two.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_SQ_K:
            begin
                mul_a = AW'(k_reg);
                mul_b = $signed(BW'(k_reg));
            end
            STEP_SQ_R:
            begin
                mul_a = AW'(r_reg);
                mul_b = $signed(BW'(r_reg));
            end
            STEP_X0:
            begin
                mul_a = w0_reg;
                mul_b = BW'(start_x_reg);
            end
            STEP_X1:
            begin
                mul_a = w1_reg;
                mul_b = BW'(ctrl_x_reg);
            end
            STEP_X2:
            begin
                mul_a = w2_reg;
                mul_b = BW'(end_x_reg);
            end
            STEP_Y0:
            begin
                mul_a = w0_reg;
                mul_b = BW'(start_y_reg);
            end
            STEP_Y1:
            begin
                mul_a = w1_reg;
                mul_b = BW'(ctrl_y_reg);
            end
            STEP_Y2:
            begin
                mul_a = w2_reg;
                mul_b = BW'(end_y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qbs_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // ------------------------------------------------------------------
    // Divide by N squared as an arithmetic shift. Negative sums are biased
    // by N squared less one so that the shift truncates toward zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        sh       = {lg_reg, 1'b0};
        nsq_pw   = PW'(1) << sh;
        nsq_aw   = AW'(1) << sh;
        bias_x   = num_x_reg[PW-1] ? nsq_pw - PW'(1) : '0;
        bias_y   = num_y_reg[PW-1] ? nsq_pw - PW'(1) : '0;
        quot_x   = (num_x_reg + bias_x) >>> sh;
        quot_y   = (num_y_reg + bias_y) >>> sh;
        sum_next = acc_reg + prod;
    end

    always_comb
    begin
        min_x_new = (px_reg < min_x_reg) ? px_reg : min_x_reg;
        min_y_new = (py_reg < min_y_reg) ? py_reg : min_y_reg;
        max_x_new = (px_reg > max_x_reg) ? px_reg : max_x_reg;
        max_y_new = (py_reg > max_y_reg) ? py_reg : max_y_reg;
    end

    // ------------------------------------------------------------------
    // Running bounding box: cleared by reset or by a restart beat, widened
    // by each finished sample.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= BOX_MIN_RESET;
            min_y_reg <= BOX_MIN_RESET;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end
        else if (accept && restart)
        begin
            min_x_reg <= BOX_MIN_RESET;
            min_y_reg <= BOX_MIN_RESET;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end
        else if (finish)
        begin
            min_x_reg <= min_x_new;
            min_y_reg <= min_y_new;
            max_x_reg <= max_x_new;
            max_y_reg <= max_y_new;
        end
    end

    // ------------------------------------------------------------------
    // Working datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            k_reg    <= k_eff;
            r_reg    <= n_val - k_eff;
            last_reg <= last_eff;
            lg_reg   <= lg_eff;
        end

        if (state_reg == QBS_RUN)
        begin
            case (step_reg)
                STEP_SQ_R:  w2_reg    <= prod[AW-1:0];
                STEP_W0:    w0_reg    <= prod[AW-1:0];
                STEP_X0:    w1_reg    <= nsq_aw - w0_reg - w2_reg;
                STEP_X1:    acc_reg   <= prod;
                STEP_X2:    acc_reg   <= sum_next;
                STEP_Y0:    num_x_reg <= sum_next;
                STEP_Y1:    acc_reg   <= prod;
                STEP_Y2:    acc_reg   <= sum_next;
                STEP_SUM_Y: num_y_reg <= sum_next;
                STEP_DIV:
                begin
                    px_reg <= quot_x[CW-1:0];
                    py_reg <= quot_y[CW-1:0];
                end
                default:    ;
            endcase
        end

        if (finish)
        begin
            point_x_reg   <= px_reg;
            point_y_reg   <= py_reg;
            last_out_reg  <= last_reg;
            box_min_x_reg <= min_x_new;
            box_min_y_reg <= min_y_new;
            box_max_x_reg <= max_x_new;
            box_max_y_reg <= max_y_new;
        end
    end

    assign in_ready  = (state_reg == QBS_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign last      = last_out_reg;
    assign box_min_x = box_min_x_reg;
    assign box_min_y = box_min_y_reg;
    assign box_max_x = box_max_x_reg;
    assign box_max_y = box_max_y_reg;

endmodule
